### rtl/mabg_pkg.sv
// Shared types and constants for the microphone array beamform/gate block.
// No dependencies.
`default_nettype none
package mabg_pkg;

    localparam int SIG_W   = 48;
    localparam int COEF_W  = 19;
    localparam int STEER_W = 12;
    localparam int MODE_W  = 2;
    localparam int IDX_W   = 3;
    localparam int CFG_W   = 12;

    localparam logic [IDX_W-1:0] REG_MODE   = 3'd0;
    localparam logic [IDX_W-1:0] REG_STEER0 = 3'd1;
    localparam logic [IDX_W-1:0] REG_STEER1 = 3'd2;
    localparam logic [IDX_W-1:0] REG_STEER2 = 3'd3;
    localparam logic [IDX_W-1:0] REG_STEER3 = 3'd4;

    localparam logic [MODE_W-1:0] MODE_STD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WIDE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_VOICE = 2'd2;

    localparam logic [COEF_W-1:0] C_DC    = 19'd65208;
    localparam logic [COEF_W-1:0] C_HP    = 19'd62587;
    localparam logic [COEF_W-1:0] C_NF_DN = 19'd64225;
    localparam logic [COEF_W-1:0] C_SMALL = 19'd1311;
    localparam logic [COEF_W-1:0] C_NF_UP = 19'd65503;
    localparam logic [COEF_W-1:0] C_NF_IN = 19'd33;
    localparam logic [COEF_W-1:0] C_THR   = 19'd163840;
    localparam logic [COEF_W-1:0] C_ATT   = 19'd22938;
    localparam logic [COEF_W-1:0] C_WIDE  = 19'd104858;

    localparam logic signed [SIG_W-1:0] SIG_MAX = {1'b0, {(SIG_W-1){1'b1}}};
    localparam logic signed [SIG_W-1:0] SIG_MIN = {1'b1, {(SIG_W-1){1'b0}}};
    localparam logic signed [SIG_W-1:0] ONE_Q16 = 48'sd65536;
    localparam logic signed [SIG_W-1:0] LOW_Q16 = 48'sd16384;

    typedef enum logic [4:0] {
        ST_IDLE, ST_LANE, ST_MIX, ST_WIDE, ST_DC, ST_HP, ST_NF0, ST_NF1,
        ST_NF2, ST_THR, ST_ENV, ST_GATE, ST_OUT
    } state_t;

    function automatic logic signed [SIG_W-1:0] sat48(input logic signed [SIG_W+3:0] x);
        if (x > 52'(SIG_MAX)) return SIG_MAX;
        if (x < 52'(SIG_MIN)) return SIG_MIN;
        return x[SIG_W-1:0];
    endfunction

endpackage
`default_nettype wire

### rtl/mabg_qmul.sv
// Shared registered fixed-point multiplier: round(a*c/2^16), half up, saturated.
// Depends on mabg_pkg. Registered, two partial products.
`default_nettype none
module mabg_qmul (
    input  wire logic                                aclk,
    input  wire logic signed [mabg_pkg::SIG_W-1:0]   a,
    input  wire logic        [mabg_pkg::COEF_W-1:0]  c,
    output logic signed      [mabg_pkg::SIG_W-1:0]   p
);
    import mabg_pkg::*;

    logic signed [31:0] hi;
    logic        [15:0] lo;
    logic signed [51:0] hi_prod_reg, hi_prod_next;
    logic        [35:0] lo_prod_reg, lo_prod_next;

    // split into integer and fraction partial products
    assign hi = a[SIG_W-1:16];
    assign lo = a[15:0];
    assign hi_prod_next = 52'(hi) * $signed({1'b0, c});
    assign lo_prod_next = 36'(lo) * 36'(c);

    always_ff @(posedge aclk) begin
        hi_prod_reg <= hi_prod_next;
        lo_prod_reg <= lo_prod_next;
    end

    assign p = sat48(hi_prod_reg + 52'((lo_prod_reg + 36'd32768) >> 16));
endmodule
`default_nettype wire

### rtl/mic_array_beamform_gate_core.sv
// Microphone array mixer: beamformer, DC blocker, high-pass and noise gate.
// Depends on mabg_pkg and mabg_qmul.
//
// A frame walks through a small sequencer that shares one registered multiplier
// and, in voice mode, writes and reads the delay memory for each lane.
// s_ready is high only while idle with the output register free; the result
// waits in an output register. After reset a clearing pass zeroes all
// MIC_LANES*DELAY_DEPTH words of the delay memory before the first frame
// is taken.
`default_nettype none
module mic_array_beamform_gate_core #(
    parameter int SAMPLE_SHIFT = 14,
    parameter int DELAY_DEPTH  = 16,
    parameter int MIC_LANES    = 4
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_we,
    input  wire logic [mabg_pkg::IDX_W-1:0]          cfg_index,
    input  wire logic [mabg_pkg::CFG_W-1:0]          cfg_data,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic signed [31:0]                  s_raw_mic_0,
    input  wire logic signed [31:0]                  s_raw_mic_1,
    input  wire logic signed [31:0]                  s_raw_mic_2,
    input  wire logic signed [31:0]                  s_raw_mic_3,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [15:0]                       m_pcm_out
);
    import mabg_pkg::*;

    localparam int PW   = $clog2(DELAY_DEPTH);
    localparam int LW   = (MIC_LANES > 1) ? $clog2(MIC_LANES) : 1;
    localparam int AW   = $clog2(MIC_LANES * DELAY_DEPTH);
    localparam int CW   = $clog2(MIC_LANES * DELAY_DEPTH + 1);
    localparam int MEMN = MIC_LANES * DELAY_DEPTH;
    localparam logic [STEER_W-1:0] MAXD = STEER_W'((DELAY_DEPTH - 2) * 256);

    // configuration
    logic [MODE_W-1:0]  mode_reg;
    logic [STEER_W-1:0] steer_reg [4];

    // state
    state_t state_reg, state_next;
    logic [CW-1:0] clr_reg;
    logic [PW-1:0] wp_reg;
    logic [LW-1:0] lane_reg;
    logic [LW:0]   rd_reg;           // lanes read and accumulated so far
    logic signed [31:0] raw_reg [4];
    logic signed [SIG_W-1:0] dc_in_reg, dc_out_reg, hp_in_reg, hp_out_reg;
    logic signed [SIG_W-1:0] nf_reg, env_reg, mixed_reg, samp_reg, mag_reg, tmp_reg;
    logic signed [SIG_W+19:0] acc_reg;
    logic sub_reg;                   // multiplier phase within a step
    logic m_valid_reg;
    logic signed [15:0] pcm_reg;

    // delay memory
    logic signed [SIG_W-1:0] mem [MEMN];
    logic signed [SIG_W-1:0] rd_a_reg, rd_b_reg;
    logic [7:0] frac_reg;

    // shared multiplier
    logic signed [SIG_W-1:0] qa, qp;
    logic [COEF_W-1:0] qc;
    mabg_qmul u_mul (.aclk(aclk), .a(qa), .c(qc), .p(qp));

    logic voice;
    assign voice = (mode_reg == MODE_VOICE);

    // lane sample for the current lane
    logic signed [31:0] raw_sel;
    logic signed [SIG_W-1:0] lane_smp;
    logic [STEER_W-1:0] d_sel;
    logic [PW-1:0] wp_cur, base, prev;
    logic [1:0] lane4;
    assign lane4    = 2'(32'(lane_reg) % 4);
    assign raw_sel  = raw_reg[lane4];
    assign lane_smp = SIG_W'(raw_sel >>> SAMPLE_SHIFT);
    assign d_sel    = (steer_reg[lane4] > MAXD) ? MAXD : steer_reg[lane4];
    // wrap pointers around the delay line by compare
    assign wp_cur   = (32'(wp_reg) == DELAY_DEPTH - 1) ? '0 : wp_reg + 1'b1;
    assign base = (32'(wp_cur) >= 32'(d_sel[STEER_W-1:8]))
                ? PW'(32'(wp_cur) - 32'(d_sel[STEER_W-1:8]))
                : PW'(32'(wp_cur) + DELAY_DEPTH - 32'(d_sel[STEER_W-1:8]));
    assign prev = (base == '0) ? PW'(DELAY_DEPTH - 1) : base - 1'b1;

    logic [AW-1:0] wr_addr, ra_addr, rb_addr;
    assign wr_addr = AW'(32'(lane_reg) * DELAY_DEPTH + 32'(wp_cur));
    assign ra_addr = AW'(32'(lane_reg) * DELAY_DEPTH + 32'(base));
    assign rb_addr = AW'(32'(lane_reg) * DELAY_DEPTH + 32'(prev));

    logic mem_we;
    logic [AW-1:0] mem_wa;
    logic signed [SIG_W-1:0] mem_wd;
    logic clearing;
    assign clearing = (clr_reg != CW'(MEMN));
    always_comb begin
        mem_we = 1'b0;
        mem_wa = wr_addr;
        mem_wd = lane_smp;
        if (clearing) begin
            mem_we = 1'b1;
            mem_wa = clr_reg[AW-1:0];
            mem_wd = '0;
        end else if (state_reg == ST_LANE && voice && sub_reg == 1'b0) begin
            mem_we = 1'b1;
        end
    end

    // memory: one write port, two registered read ports (write-first by forwarding)
    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        rd_a_reg <= (mem_we && mem_wa == ra_addr) ? mem_wd : mem[ra_addr];
        rd_b_reg <= (mem_we && mem_wa == rb_addr) ? mem_wd : mem[rb_addr];
        frac_reg <= d_sel[7:0];
    end

    logic signed [SIG_W-1:0] dc_pre, hp_pre, nf_sum;
    logic signed [SIG_W+3:0] tmp_add;
    assign dc_pre = sat48(52'(mixed_reg) - 52'(dc_in_reg) + 52'(qp));
    assign hp_pre = sat48(52'(hp_out_reg) + 52'(samp_reg) - 52'(hp_in_reg));
    assign tmp_add = 52'(tmp_reg) + 52'(qp);
    assign nf_sum = sat48(tmp_add);

    // multiplier operand selection
    always_comb begin
        qa = dc_out_reg;
        qc = C_DC;
        case (state_reg)
            ST_WIDE: begin qa = mixed_reg;  qc = C_WIDE; end
            ST_DC:   begin qa = dc_out_reg; qc = C_DC; end
            ST_HP:   begin qa = hp_pre;     qc = C_HP; end
            ST_NF0:  begin qa = nf_reg;     qc = (mag_reg < nf_reg) ? C_NF_DN : C_NF_UP; end
            ST_NF1:  begin qa = mag_reg;    qc = (mag_reg < nf_reg) ? C_SMALL : C_NF_IN; end
            ST_THR:  begin qa = nf_reg;     qc = C_THR; end
            ST_ENV:  begin
                qa = tmp_reg - env_reg;
                qc = (tmp_reg > env_reg) ? C_ATT : C_SMALL;
            end
            ST_GATE: begin qa = samp_reg;   qc = COEF_W'(env_reg); end
            default: begin qa = dc_out_reg; qc = C_DC; end
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_valid && s_ready) state_next = ST_LANE;
            ST_LANE: if (!voice || sub_reg) begin
                if (32'(lane_reg) == MIC_LANES - 1) state_next = ST_MIX;
            end
            ST_MIX:  if (!voice || 32'(rd_reg) == MIC_LANES)
                state_next = (mode_reg == MODE_WIDE) ? ST_WIDE : ST_DC;
            ST_WIDE: if (sub_reg) state_next = ST_DC;
            ST_DC:   if (sub_reg) state_next = voice ? ST_HP : ST_OUT;
            ST_HP:   if (sub_reg) state_next = ST_NF0;
            ST_NF0:  if (sub_reg) state_next = ST_NF1;
            ST_NF1:  if (sub_reg) state_next = ST_NF2;
            ST_NF2:  state_next = ST_THR;
            ST_THR:  if (sub_reg) state_next = ST_ENV;
            ST_ENV:  if (sub_reg) state_next = ST_GATE;
            ST_GATE: if (sub_reg) state_next = ST_OUT;
            ST_OUT:  if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_ready = (state_reg == ST_IDLE) && !clearing && (!m_valid_reg || m_ready);
    end
    assign m_valid   = m_valid_reg;
    assign m_pcm_out = pcm_reg;

    logic signed [SIG_W+19:0] acc_term;
    assign acc_term = 68'(rd_a_reg) * $signed({1'b0, 9'(256 - 32'(frac_reg))})
                    + 68'(rd_b_reg) * $signed({1'b0, 9'(frac_reg)});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            clr_reg     <= '0;
            wp_reg      <= '0;
            lane_reg    <= '0;
            rd_reg      <= '0;
            sub_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
            mode_reg    <= MODE_STD;
            for (int i = 0; i < 4; i++) steer_reg[i] <= '0;
            dc_in_reg <= '0; dc_out_reg <= '0; hp_in_reg <= '0; hp_out_reg <= '0;
            nf_reg <= '0; env_reg <= ONE_Q16;
        end else begin
            state_reg <= state_next;
            if (clearing) clr_reg <= clr_reg + 1'b1;
            if (m_valid_reg && m_ready && state_reg != ST_OUT) m_valid_reg <= 1'b0;

            // apply configuration writes
            if (cfg_we) begin
                if (cfg_index == REG_MODE) begin
                    mode_reg <= cfg_data[MODE_W-1:0];
                    nf_reg   <= '0;
                    env_reg  <= ONE_Q16;
                end else if (cfg_index >= REG_STEER0 && cfg_index <= REG_STEER3) begin
                    steer_reg[2'(cfg_index - REG_STEER0)] <= cfg_data;
                end
            end

            case (state_reg)
                ST_IDLE: if (s_valid && s_ready) begin
                    raw_reg[0] <= s_raw_mic_0; raw_reg[1] <= s_raw_mic_1;
                    raw_reg[2] <= s_raw_mic_2; raw_reg[3] <= s_raw_mic_3;
                    lane_reg <= '0; rd_reg <= '0; sub_reg <= 1'b0; acc_reg <= '0;
                end
                ST_LANE: begin
                    // voice: write lane then read it; others: accumulate directly
                    if (voice) begin
                        sub_reg <= ~sub_reg;
                        if (sub_reg) begin
                            rd_reg <= rd_reg + 1'b1;
                            acc_reg <= acc_reg + acc_term;
                            if (32'(lane_reg) == MIC_LANES - 1) wp_reg <= wp_cur;
                            else lane_reg <= lane_reg + 1'b1;
                        end
                    end else begin
                        acc_reg <= acc_reg + 68'(lane_smp);
                        if (32'(lane_reg) != MIC_LANES - 1) lane_reg <= lane_reg + 1'b1;
                    end
                end
                ST_MIX: begin
                    if (voice && 32'(rd_reg) != MIC_LANES) begin
                        acc_reg <= acc_reg + acc_term;
                        rd_reg  <= rd_reg + 1'b1;
                    end else begin
                        if (voice && (acc_reg > 68'sh1FF_FFFF_FFFF ||
                                      acc_reg < -68'sh200_0000_0000))
                            mixed_reg <= acc_reg[67] ? SIG_MIN : SIG_MAX;
                        else if (!voice && (acc_reg > 68'sh1_FFFF_FFFF ||
                                            acc_reg < -68'sh2_0000_0000))
                            mixed_reg <= acc_reg[67] ? SIG_MIN : SIG_MAX;
                        else
                            mixed_reg <= sat48(52'(voice ? (acc_reg <<< 6) : (acc_reg <<< 14)));
                        sub_reg <= 1'b0;
                    end
                end
                ST_WIDE: begin
                    sub_reg <= ~sub_reg;
                    if (sub_reg) mixed_reg <= qp;
                end
                ST_DC: begin
                    sub_reg <= ~sub_reg;
                    if (sub_reg) begin
                        dc_in_reg <= mixed_reg; dc_out_reg <= dc_pre; samp_reg <= dc_pre;
                    end
                end
                ST_HP: begin
                    sub_reg <= ~sub_reg;
                    if (sub_reg) begin
                        hp_in_reg <= samp_reg; hp_out_reg <= qp; samp_reg <= qp;
                        mag_reg <= qp[SIG_W-1] ? sat48(-52'(qp)) : qp;
                        if (nf_reg == '0) nf_reg <= qp[SIG_W-1] ? sat48(-52'(qp)) : qp;
                    end
                end
                ST_NF0: begin
                    sub_reg <= ~sub_reg;
                    if (sub_reg) tmp_reg <= qp;
                end
                ST_NF1: begin
                    sub_reg <= ~sub_reg;
                    if (sub_reg) tmp_reg <= nf_sum;
                end
                ST_NF2: nf_reg <= tmp_reg;
                ST_THR: begin
                    sub_reg <= ~sub_reg;
                    if (sub_reg) tmp_reg <= (mag_reg > qp) ? ONE_Q16 : LOW_Q16;
                end
                ST_ENV: begin
                    sub_reg <= ~sub_reg;
                    if (sub_reg) env_reg <= env_reg + qp;
                end
                ST_GATE: begin
                    sub_reg <= ~sub_reg;
                    if (sub_reg) samp_reg <= qp;
                end
                ST_OUT: if (!m_valid_reg || m_ready) begin
                    m_valid_reg <= 1'b1;
                    if (samp_reg > 48'sd2147418112) pcm_reg <= 16'sd32767;
                    else if (samp_reg < -48'sd2147483648) pcm_reg <= -16'sd32768;
                    else if (samp_reg[SIG_W-1] && samp_reg[15:0] != '0)
                        pcm_reg <= 16'(samp_reg[31:16] + 16'sd1);
                    else pcm_reg <= samp_reg[31:16];
                end
                default: ;
            endcase
        end
    end

    // checks on the sequencer
    a_no_take_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready) else $error("input taken while busy");
    a_no_take_clr: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing |-> !s_ready) else $error("input taken during clear");
    a_out_after: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg) == ST_OUT) else $error("stray result");
    a_env_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (env_reg <= ONE_Q16 && env_reg >= 48'sd0)) else $error("envelope out of range");
endmodule
`default_nettype wire
